// File: src/sgp_pkg.sv
// Shared types, widths and constants for the sharpen gain pipeline.
package sgp_pkg;

    localparam int AMT_W   = 16;
    localparam int DIST_W  = 24;
    localparam int MASK_W  = 16;
    localparam int LUMA_W  = 16;
    localparam int QUO_W   = 16;
    localparam int NUM_W   = 41;
    localparam int DEN_W   = 24;
    localparam int PROD_W  = 40;
    localparam int XX_W    = 32;
    localparam int SFAC_W  = 18;
    localparam int SPROD_W = 50;
    localparam int FMAG_W  = 32;
    localparam int GATE_W  = 17;
    localparam int G_W     = 17;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 7;
    localparam int LATENCY      = FRONT_STAGES + QUO_W + BACK_STAGES;

    localparam logic [GATE_W-1:0]  GATE_ONE   = 17'h1_0000;
    localparam logic [SFAC_W-1:0]  SMOOTH_K   = 18'd196608;
    localparam logic [SPROD_W-1:0] SMOOTH_RND = 50'h0_0000_8000_0000;
    localparam logic [FMAG_W-1:0]  FOL_RND    = 32'd32767;
    localparam logic [16:0]        FOL_DIV    = 17'd65535;
    localparam logic [16:0]        FOL_DIV2   = 17'd131070;
    localparam logic [33:0]        ROUND_Q16  = 34'd32768;

    typedef enum logic [IDX_W-1:0] {
        REG_NEAR_AMOUNT    = 3'd0,
        REG_FAR_AMOUNT     = 3'd1,
        REG_NEAR_DISTANCE  = 3'd2,
        REG_FAR_DISTANCE   = 3'd3,
        REG_FOLIAGE_AMOUNT = 3'd4,
        REG_SHADOW_FLOOR   = 3'd5,
        REG_MAX_AMOUNT     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [AMT_W-1:0]  near_amount;
        logic [AMT_W-1:0]  far_amount;
        logic [DIST_W-1:0] near_distance;
        logic [DIST_W-1:0] far_distance;
        logic [AMT_W-1:0]  foliage_amount;
        logic [LUMA_W-1:0] shadow_floor;
        logic [AMT_W-1:0]  max_amount;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        near_amount:    16'd4096,
        far_amount:     16'd4096,
        near_distance:  24'd0,
        far_distance:   24'd0,
        foliage_amount: 16'd4096,
        shadow_floor:   16'd0,
        max_amount:     16'd8192
    };

    typedef struct packed {
        logic              amt_up;
        logic              sel_near;
        logic              sel_far;
        logic              gate_one;
        logic [MASK_W-1:0] mask;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] dnum;
        logic [DEN_W-1:0] dden;
        logic [NUM_W-1:0] lnum;
    } div_req_t;

endpackage

// File: src/sgp_pipe_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sgp_pipe_div (
    input  logic                      clk,
    input  logic [sgp_pkg::NUM_W-1:0] num,
    input  logic [sgp_pkg::DEN_W-1:0] den,
    output logic [sgp_pkg::QUO_W-1:0] quo
);

    logic [sgp_pkg::NUM_W-1:0] rem_reg [sgp_pkg::QUO_W-1];
    logic [sgp_pkg::DEN_W-1:0] den_reg [sgp_pkg::QUO_W-1];
    logic [sgp_pkg::QUO_W-1:0] quo_reg [sgp_pkg::QUO_W];

    for (genvar k = 0; k < sgp_pkg::QUO_W; k++)
    begin : g_stage
        logic [sgp_pkg::NUM_W-1:0] rem_in;
        logic [sgp_pkg::DEN_W-1:0] den_in;
        logic [sgp_pkg::QUO_W-1:0] quo_in;
        logic [sgp_pkg::NUM_W-1:0] trial;
        logic                      take;
        logic [sgp_pkg::QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_chain
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial    = sgp_pkg::NUM_W'(den_in) << (sgp_pkg::QUO_W - 1 - k);
        assign take     = rem_in >= trial;
        assign quo_next = quo_in | (sgp_pkg::QUO_W'(take) << (sgp_pkg::QUO_W - 1 - k));

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= quo_next;
        end

        if (k < sgp_pkg::QUO_W - 1)
        begin : g_carry
            logic [sgp_pkg::NUM_W-1:0] rem_next;

            assign rem_next = take ? (rem_in - trial) : rem_in;

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[sgp_pkg::QUO_W-1];

endmodule

// File: src/sgp_front.sv
// Front stages: band selection, distance product and divider operands.
module sgp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sgp_pkg::DIST_W-1:0] distance,
    input  logic [sgp_pkg::MASK_W-1:0] foliage_mask,
    input  logic [sgp_pkg::LUMA_W-1:0] luma,
    input  sgp_pkg::cfg_t              cfg,
    output logic                       out_valid,
    output sgp_pkg::div_req_t          req,
    output sgp_pkg::side_t             side
);

    logic [sgp_pkg::FRONT_STAGES-1:0] valid_reg;

    logic [sgp_pkg::DIST_W-1:0] off1_reg, off1_next;
    logic [sgp_pkg::DEN_W-1:0]  den1_reg, den1_next;
    logic [sgp_pkg::AMT_W-1:0]  amag1_reg, amag1_next;
    logic [sgp_pkg::LUMA_W-1:0] luma1_reg;
    sgp_pkg::side_t             side1_reg, side1_next;

    logic [sgp_pkg::PROD_W-1:0] prod2_reg, prod2_next;
    logic [sgp_pkg::DEN_W-1:0]  den2_reg;
    logic [sgp_pkg::LUMA_W-1:0] luma2_reg;
    sgp_pkg::side_t             side2_reg;

    sgp_pkg::div_req_t          req3_reg, req3_next;
    sgp_pkg::side_t             side3_reg;

    always_comb
    begin
        off1_next = distance - cfg.near_distance;
        den1_next = cfg.far_distance - cfg.near_distance;
        side1_next.amt_up = cfg.far_amount >= cfg.near_amount;
        if (side1_next.amt_up)
        begin
            amag1_next = cfg.far_amount - cfg.near_amount;
        end
        else
        begin
            amag1_next = cfg.near_amount - cfg.far_amount;
        end
        side1_next.sel_near = (cfg.far_distance <= cfg.near_distance)
                              || (distance <= cfg.near_distance);
        side1_next.sel_far  = distance >= cfg.far_distance;
        side1_next.gate_one = (cfg.shadow_floor == '0) || (luma >= cfg.shadow_floor);
        side1_next.mask     = foliage_mask;
    end

    assign prod2_next = sgp_pkg::PROD_W'(amag1_reg) * sgp_pkg::PROD_W'(off1_reg);

    always_comb
    begin
        req3_next.dnum = sgp_pkg::NUM_W'(prod2_reg) + sgp_pkg::NUM_W'(den2_reg >> 1);
        req3_next.dden = den2_reg;
        req3_next.lnum = sgp_pkg::NUM_W'({luma2_reg, {sgp_pkg::LUMA_W{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[sgp_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        off1_reg  <= off1_next;
        den1_reg  <= den1_next;
        amag1_reg <= amag1_next;
        luma1_reg <= luma;
        side1_reg <= side1_next;

        prod2_reg <= prod2_next;
        den2_reg  <= den1_reg;
        luma2_reg <= luma1_reg;
        side2_reg <= side1_reg;

        req3_reg  <= req3_next;
        side3_reg <= side2_reg;
    end

    assign out_valid = valid_reg[sgp_pkg::FRONT_STAGES-1];
    assign req       = req3_reg;
    assign side      = side3_reg;

endmodule

// File: src/sgp_back.sv
// Back stages: distance gain, foliage blend, smoothstep gate and clamp.
module sgp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  sgp_pkg::side_t             side,
    input  logic [sgp_pkg::QUO_W-1:0]  dq,
    input  logic [sgp_pkg::QUO_W-1:0]  x,
    input  sgp_pkg::cfg_t              cfg,
    output logic                       out_valid,
    output logic [sgp_pkg::AMT_W-1:0]  gain
);

    logic [sgp_pkg::BACK_STAGES-1:0] valid_reg;

    // stage 1
    logic [sgp_pkg::AMT_W-1:0]  d1_reg, d1_next;
    logic [sgp_pkg::QUO_W-1:0]  x1_reg;
    logic [sgp_pkg::MASK_W-1:0] mask1_reg;
    logic                       gate1_reg;

    // stage 2
    logic [sgp_pkg::AMT_W-1:0]  d2_reg;
    logic [sgp_pkg::AMT_W-1:0]  fdiff2_reg, fdiff2_next;
    logic                       fup2_reg, fup2_next;
    logic [sgp_pkg::XX_W-1:0]   xx2_reg, xx2_next;
    logic [sgp_pkg::QUO_W-1:0]  x2_reg;
    logic [sgp_pkg::MASK_W-1:0] mask2_reg;
    logic                       gate2_reg;

    // stage 3
    logic [sgp_pkg::AMT_W-1:0]   d3_reg;
    logic                        fup3_reg;
    logic                        gate3_reg;
    logic [sgp_pkg::FMAG_W-1:0]  fmag3_reg, fmag3_next;
    logic [sgp_pkg::SFAC_W-1:0]  sfac;
    logic [sgp_pkg::SPROD_W-1:0] sprod3_reg, sprod3_next;

    // stage 4
    logic [sgp_pkg::FMAG_W-1:0]  fnum;
    logic [16:0]                 fres;
    logic [sgp_pkg::SPROD_W-1:0] ssum;
    logic [sgp_pkg::AMT_W-1:0]   d4_reg;
    logic                        fup4_reg;
    logic [sgp_pkg::AMT_W-1:0]   fq4_reg, fq4_next;
    logic [sgp_pkg::GATE_W-1:0]  s4_reg, s4_next;

    // stage 5
    logic [sgp_pkg::AMT_W-1:0]  f5_reg, f5_next;
    logic [sgp_pkg::GATE_W-1:0] s5_reg;

    // stage 6
    logic [33:0]             gsum;
    logic [sgp_pkg::G_W-1:0] g6_reg, g6_next;

    // stage 7
    logic [sgp_pkg::AMT_W-1:0] gain7_reg, gain7_next;

    always_comb
    begin
        if (side.sel_near)
        begin
            d1_next = cfg.near_amount;
        end
        else if (side.sel_far)
        begin
            d1_next = cfg.far_amount;
        end
        else if (side.amt_up)
        begin
            d1_next = cfg.near_amount + dq;
        end
        else
        begin
            d1_next = cfg.near_amount - dq;
        end
    end

    always_comb
    begin
        fup2_next = cfg.foliage_amount >= d1_reg;
        if (fup2_next)
        begin
            fdiff2_next = cfg.foliage_amount - d1_reg;
        end
        else
        begin
            fdiff2_next = d1_reg - cfg.foliage_amount;
        end
        xx2_next = sgp_pkg::XX_W'(x1_reg) * sgp_pkg::XX_W'(x1_reg);
    end

    assign sfac        = sgp_pkg::SMOOTH_K - sgp_pkg::SFAC_W'({x2_reg, 1'b0});
    assign fmag3_next  = sgp_pkg::FMAG_W'(fdiff2_reg) * sgp_pkg::FMAG_W'(mask2_reg);
    assign sprod3_next = sgp_pkg::SPROD_W'(xx2_reg) * sgp_pkg::SPROD_W'(sfac);

    // divide by 65535: quotient estimate from the high half, remainder fixup
    always_comb
    begin
        fnum     = fmag3_reg + sgp_pkg::FOL_RND;
        fres     = 17'(fnum[31:16]) + 17'(fnum[15:0]);
        fq4_next = fnum[31:16]
                   + sgp_pkg::AMT_W'(fres >= sgp_pkg::FOL_DIV)
                   + sgp_pkg::AMT_W'(fres >= sgp_pkg::FOL_DIV2);
        ssum     = sprod3_reg + sgp_pkg::SMOOTH_RND;
        s4_next  = gate3_reg ? sgp_pkg::GATE_ONE : ssum[32 +: sgp_pkg::GATE_W];
    end

    assign f5_next = fup4_reg ? (d4_reg + fq4_reg) : (d4_reg - fq4_reg);

    always_comb
    begin
        gsum    = 34'(33'(f5_reg) * 33'(s5_reg)) + sgp_pkg::ROUND_Q16;
        g6_next = gsum[16 +: sgp_pkg::G_W];
    end

    always_comb
    begin
        if (g6_reg > sgp_pkg::G_W'(cfg.max_amount))
        begin
            gain7_next = cfg.max_amount;
        end
        else
        begin
            gain7_next = g6_reg[sgp_pkg::AMT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[sgp_pkg::BACK_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg     <= d1_next;
        x1_reg     <= x;
        mask1_reg  <= side.mask;
        gate1_reg  <= side.gate_one;

        d2_reg     <= d1_reg;
        fdiff2_reg <= fdiff2_next;
        fup2_reg   <= fup2_next;
        xx2_reg    <= xx2_next;
        x2_reg     <= x1_reg;
        mask2_reg  <= mask1_reg;
        gate2_reg  <= gate1_reg;

        d3_reg     <= d2_reg;
        fup3_reg   <= fup2_reg;
        gate3_reg  <= gate2_reg;
        fmag3_reg  <= fmag3_next;
        sprod3_reg <= sprod3_next;

        d4_reg     <= d3_reg;
        fup4_reg   <= fup3_reg;
        fq4_reg    <= fq4_next;
        s4_reg     <= s4_next;

        f5_reg     <= f5_next;
        s5_reg     <= s4_reg;

        g6_reg     <= g6_next;

        gain7_reg  <= gain7_next;
    end

    assign out_valid = valid_reg[sgp_pkg::BACK_STAGES-1];
    assign gain      = gain7_reg;

endmodule

// File: src/sharpen_gain_per_pixel.sv
// Top level of the per-pixel sharpen gain pipeline with its register port.
// An accepted transaction passes 3 front stages, the 16-stage divider (one quotient bit
// each) and 7 back stages to the done strobe.
// Throughput: one transaction per clock; busy stays low.
// Reset clears all valid bits and loads register defaults; done cannot be held off.
module sharpen_gain_per_pixel (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sgp_pkg::DIST_W-1:0] distance,
    input  logic [sgp_pkg::MASK_W-1:0] foliage_mask,
    input  logic [sgp_pkg::LUMA_W-1:0] luma,
    output logic                       done,
    output logic [sgp_pkg::AMT_W-1:0]  gain,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sgp_pkg::ADDR_W-1:0] paddr,
    input  logic [sgp_pkg::DATA_W-1:0] pwdata,
    output logic [sgp_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    sgp_pkg::cfg_t     cfg_reg, cfg_next;
    sgp_pkg::reg_idx_t idx;
    logic              wr_en;

    logic              fr_valid;
    sgp_pkg::div_req_t fr_req;
    sgp_pkg::side_t    fr_side;

    logic                          vdly_reg [sgp_pkg::QUO_W];
    sgp_pkg::side_t                sdly_reg [sgp_pkg::QUO_W];
    logic [sgp_pkg::QUO_W-1:0]     dq;
    logic [sgp_pkg::QUO_W-1:0]     xq;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = sgp_pkg::reg_idx_t'(paddr[sgp_pkg::ADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                sgp_pkg::REG_NEAR_AMOUNT:    cfg_next.near_amount    = pwdata[15:0];
                sgp_pkg::REG_FAR_AMOUNT:     cfg_next.far_amount     = pwdata[15:0];
                sgp_pkg::REG_NEAR_DISTANCE:  cfg_next.near_distance  = pwdata[23:0];
                sgp_pkg::REG_FAR_DISTANCE:   cfg_next.far_distance   = pwdata[23:0];
                sgp_pkg::REG_FOLIAGE_AMOUNT: cfg_next.foliage_amount = pwdata[15:0];
                sgp_pkg::REG_SHADOW_FLOOR:   cfg_next.shadow_floor   = pwdata[15:0];
                sgp_pkg::REG_MAX_AMOUNT:     cfg_next.max_amount     = pwdata[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sgp_pkg::REG_NEAR_AMOUNT:    prdata = sgp_pkg::DATA_W'(cfg_reg.near_amount);
            sgp_pkg::REG_FAR_AMOUNT:     prdata = sgp_pkg::DATA_W'(cfg_reg.far_amount);
            sgp_pkg::REG_NEAR_DISTANCE:  prdata = sgp_pkg::DATA_W'(cfg_reg.near_distance);
            sgp_pkg::REG_FAR_DISTANCE:   prdata = sgp_pkg::DATA_W'(cfg_reg.far_distance);
            sgp_pkg::REG_FOLIAGE_AMOUNT: prdata = sgp_pkg::DATA_W'(cfg_reg.foliage_amount);
            sgp_pkg::REG_SHADOW_FLOOR:   prdata = sgp_pkg::DATA_W'(cfg_reg.shadow_floor);
            sgp_pkg::REG_MAX_AMOUNT:     prdata = sgp_pkg::DATA_W'(cfg_reg.max_amount);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sgp_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sgp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .distance     (distance),
        .foliage_mask (foliage_mask),
        .luma         (luma),
        .cfg          (cfg_reg),
        .out_valid    (fr_valid),
        .req          (fr_req),
        .side         (fr_side)
    );

    sgp_pipe_div u_div_dist (
        .clk (clk),
        .num (fr_req.dnum),
        .den (fr_req.dden),
        .quo (dq)
    );

    sgp_pipe_div u_div_luma (
        .clk (clk),
        .num (fr_req.lnum),
        .den (sgp_pkg::DEN_W'(cfg_reg.shadow_floor)),
        .quo (xq)
    );

    // sideband travels alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sgp_pkg::QUO_W; i++)
            begin
                vdly_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vdly_reg[0] <= fr_valid;
            for (int i = 1; i < sgp_pkg::QUO_W; i++)
            begin
                vdly_reg[i] <= vdly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sdly_reg[0] <= fr_side;
        for (int i = 1; i < sgp_pkg::QUO_W; i++)
        begin
            sdly_reg[i] <= sdly_reg[i-1];
        end
    end

    sgp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vdly_reg[sgp_pkg::QUO_W-1]),
        .side      (sdly_reg[sgp_pkg::QUO_W-1]),
        .dq        (dq),
        .x         (xq),
        .cfg       (cfg_reg),
        .out_valid (done),
        .gain      (gain)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(sgp_pkg::LATENCY) done)
        else $error("accepted transaction did not complete on time");

    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, sgp_pkg::LATENCY))
        else $error("done without a matching transaction");

    a_side_align: assert property (@(posedge clk) disable iff (!rst_n)
        vdly_reg[sgp_pkg::QUO_W-1] |-> $past(fr_valid, sgp_pkg::QUO_W))
        else $error("sideband out of step with divider");

    a_prdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!wr_en) && $stable(paddr)) |-> $stable(prdata))
        else $error("read data changed without a write");

endmodule

// File: sim/tb_sharpen_gain_per_pixel.sv
`timescale 1ns / 100ps
// Self-checking testbench for the per-pixel sharpen gain block and its register port.
module tb_sharpen_gain_per_pixel;
    import sgp_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE   = 3'd7;
    localparam int               ROW_N       = 26;
    localparam int               PHASE_N     = 9;
    localparam int               PHASE_ITEMS = 100;
    localparam int               QUIET_LIMIT = 1000;

    typedef struct packed {
        logic              is_write;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wdata;
        logic [DIST_W-1:0] dist_cm;
        logic [MASK_W-1:0] mask;
        logic [LUMA_W-1:0] lum;
        logic              typed;
        logic [AMT_W-1:0]  want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [DIST_W-1:0]   distance;
    logic [MASK_W-1:0]   foliage_mask;
    logic [LUMA_W-1:0]   luma;
    logic                done;
    logic [AMT_W-1:0]    gain;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cfg_t                regs = CFG_RESET;
    logic [AMT_W-1:0]    pending_gain[$];
    logic [AMT_W-1:0]    head_gain;
    int                  err_count = 0;
    int                  quiet = 0;
    row_t                directed_rows [0:ROW_N-1];

    sharpen_gain_per_pixel i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .distance     (distance),
        .foliage_mask (foliage_mask),
        .luma         (luma),
        .done         (done),
        .gain         (gain),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // a moved toward b by num/den, magnitude rounded half up
    function automatic longint unsigned step_toward(longint unsigned a, longint unsigned b,
                                                    longint unsigned num,
                                                    longint unsigned den);
        if (b >= a)
            return a + ((b - a) * num + den / 2) / den;
        return a - ((a - b) * num + den / 2) / den;
    endfunction

    function automatic logic [AMT_W-1:0] predict_gain(cfg_t c, logic [DIST_W-1:0] dist_cm,
                                                      logic [MASK_W-1:0] mask,
                                                      logic [LUMA_W-1:0] lum);
        longint unsigned dist_gain;
        longint unsigned leaf_gain;
        longint unsigned shade;
        longint unsigned x;
        longint unsigned g;
        if (c.far_distance <= c.near_distance || dist_cm <= c.near_distance)
            dist_gain = c.near_amount;
        else if (dist_cm >= c.far_distance)
            dist_gain = c.far_amount;
        else
            dist_gain = step_toward(c.near_amount, c.far_amount,
                                    longint'(dist_cm) - longint'(c.near_distance),
                                    longint'(c.far_distance) - longint'(c.near_distance));
        leaf_gain = step_toward(dist_gain, c.foliage_amount, mask, 65535);
        if (c.shadow_floor == 0 || lum >= c.shadow_floor)
            shade = 65536;
        else
        begin
            x = (longint'(lum) << 16) / longint'(c.shadow_floor);
            shade = (x * x * (196608 - 2 * x) + 64'h8000_0000) >> 32;
        end
        g = (leaf_gain * shade + 32768) >> 16;
        if (g > c.max_amount)
            g = c.max_amount;
        return g[AMT_W-1:0];
    endfunction

    function automatic void store_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            REG_NEAR_AMOUNT:    regs.near_amount    = data[AMT_W-1:0];
            REG_FAR_AMOUNT:     regs.far_amount     = data[AMT_W-1:0];
            REG_NEAR_DISTANCE:  regs.near_distance  = data[DIST_W-1:0];
            REG_FAR_DISTANCE:   regs.far_distance   = data[DIST_W-1:0];
            REG_FOLIAGE_AMOUNT: regs.foliage_amount = data[AMT_W-1:0];
            REG_SHADOW_FLOOR:   regs.shadow_floor   = data[LUMA_W-1:0];
            REG_MAX_AMOUNT:     regs.max_amount     = data[AMT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(logic [IDX_W-1:0] idx);
        case (idx)
            REG_NEAR_AMOUNT:    return DATA_W'(regs.near_amount);
            REG_FAR_AMOUNT:     return DATA_W'(regs.far_amount);
            REG_NEAR_DISTANCE:  return DATA_W'(regs.near_distance);
            REG_FAR_DISTANCE:   return DATA_W'(regs.far_distance);
            REG_FOLIAGE_AMOUNT: return DATA_W'(regs.foliage_amount);
            REG_SHADOW_FLOOR:   return DATA_W'(regs.shadow_floor);
            REG_MAX_AMOUNT:     return DATA_W'(regs.max_amount);
            default:            return '0;
        endcase
    endfunction

    function automatic row_t wr(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.idx = idx;
        r.wdata = data;
        return r;
    endfunction

    function automatic row_t pix(logic [DIST_W-1:0] dist_cm, logic [MASK_W-1:0] mask,
                                 logic [LUMA_W-1:0] lum);
        row_t r;
        r = '0;
        r.dist_cm = dist_cm;
        r.mask = mask;
        r.lum = lum;
        return r;
    endfunction

    function automatic row_t chk(logic [DIST_W-1:0] dist_cm, logic [MASK_W-1:0] mask,
                                 logic [LUMA_W-1:0] lum, logic [AMT_W-1:0] want);
        row_t r;
        r = pix(dist_cm, mask, lum);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    // all tasks below are entered and left just after a falling edge
    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        store_reg(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_check(input logic [IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== reg_value(idx))
            report_mismatch($sformatf("readback of register %0d", idx), prdata, reg_value(idx));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_gain.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [DIST_W-1:0] dist_cm, input logic [MASK_W-1:0] mask,
                              input logic [LUMA_W-1:0] lum, input logic typed,
                              input logic [AMT_W-1:0] want, input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        distance     <= dist_cm;
        foliage_mask <= mask;
        luma         <= lum;
        do @(posedge clk); while (busy);
        pending_gain.push_back(typed ? want : predict_gain(regs, dist_cm, mask, lum));
        @(negedge clk);
    endtask

    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return AMT_W'($urandom_range(0, 16'h2000));
            default: return AMT_W'($urandom());
        endcase
    endfunction

    task automatic configure_phase(input int phase);
        logic [DATA_W-1:0] junk;
        logic [AMT_W-1:0]  na, fa, fol, flo, mx;
        logic [DIST_W-1:0] nd, fd;
        if (phase == 0)
        begin
            na = '0; fa = '1; nd = '0; fd = '1; fol = '1; flo = '1; mx = '1;
        end
        else if (phase == 1)
        begin
            na = '0; fa = '0; nd = '0; fd = '0; fol = '0; flo = '0; mx = '0;
        end
        else
        begin
            na  = pick_amount();
            fa  = pick_amount();
            fol = pick_amount();
            mx  = ($urandom_range(0, 3) == 0) ? pick_amount() : '1;
            case ($urandom_range(0, 3))
                0:       flo = '0;
                1:       flo = '1;
                default: flo = AMT_W'($urandom());
            endcase
            nd = DIST_W'($urandom_range(0, 3000));
            case ($urandom_range(0, 4))
                0:       fd = DIST_W'($urandom_range(0, nd));
                1:       fd = '1;
                default: fd = nd + DIST_W'($urandom_range(1, 5000));
            endcase
        end
        drain();
        junk = $urandom();
        apb_write(REG_NEAR_AMOUNT,    {junk[31:16], na});
        apb_write(REG_FAR_AMOUNT,     {junk[15:0],  fa});
        apb_write(REG_NEAR_DISTANCE,  {junk[31:24], nd});
        apb_write(REG_FAR_DISTANCE,   {junk[23:16], fd});
        apb_write(REG_FOLIAGE_AMOUNT, {junk[23:8],  fol});
        apb_write(REG_SHADOW_FLOOR,   {junk[27:12], flo});
        apb_write(REG_MAX_AMOUNT,     {junk[19:4],  mx});
        for (int i = 0; i <= REG_MAX_AMOUNT; i++)
            apb_check(IDX_W'(i));
    endtask

    task automatic random_pixel(input int max_gap);
        logic [DIST_W-1:0] dist_cm;
        logic [MASK_W-1:0] mask;
        logic [LUMA_W-1:0] lum;
        case ($urandom_range(0, 7))
            0:       dist_cm = '0;
            1:       dist_cm = '1;
            2:       dist_cm = regs.near_distance;
            3:       dist_cm = regs.far_distance;
            4, 5, 6: dist_cm = DIST_W'($urandom_range(0, regs.far_distance + 64));
            default: dist_cm = DIST_W'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0:       mask = '0;
            1:       mask = '1;
            default: mask = MASK_W'($urandom());
        endcase
        if (regs.shadow_floor != 0 && $urandom_range(0, 2) != 0)
            lum = LUMA_W'($urandom_range(0, regs.shadow_floor));
        else
            lum = LUMA_W'($urandom());
        send_pixel(dist_cm, mask, lum, 1'b0, '0, max_gap);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_gain.size() == 0)
                report_mismatch("gain with no transaction pending", gain, 0);
            else
            begin
                head_gain = pending_gain.pop_front();
                if (gain !== head_gain)
                    report_mismatch("gain", gain, head_gain);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("sharpen_gain_per_pixel: mismatch");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        distance     = '0;
        foliage_mask = '0;
        luma         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        directed_rows = '{
            chk(24'h000000, 16'h0000, 16'h0000, 16'h1000),
            chk(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h1000),
            chk(24'h123456, 16'h8000, 16'h1000, 16'h1000),
            wr(REG_MAX_AMOUNT,     32'hFFFF_FFFF),
            wr(REG_NEAR_AMOUNT,    32'h5A5A_0000),
            wr(REG_FAR_AMOUNT,     32'hABCD_FFFF),
            wr(REG_NEAR_DISTANCE,  32'h0000_1000),
            wr(REG_FAR_DISTANCE,   32'hFF00_2000),
            wr(REG_SPARE,          32'h0000_0000),
            chk(24'h000000, 16'h0000, 16'hFFFF, 16'h0000),
            chk(24'h001000, 16'h0000, 16'hFFFF, 16'h0000),
            chk(24'h002000, 16'h0000, 16'hFFFF, 16'hFFFF),
            chk(24'hFFFFFF, 16'h0000, 16'h0000, 16'hFFFF),
            pix(24'h001800, 16'h0000, 16'h8000),
            chk(24'h001800, 16'hFFFF, 16'hFFFF, 16'h1000),
            pix(24'h001388, 16'h8000, 16'h0000),
            wr(REG_SHADOW_FLOOR,   32'h1234_1000),
            chk(24'h002000, 16'h0000, 16'h0000, 16'h0000),
            chk(24'h002000, 16'h0000, 16'h1000, 16'hFFFF),
            pix(24'h002000, 16'h0000, 16'h0800),
            pix(24'h001800, 16'h7FFF, 16'h0FFF),
            wr(REG_FOLIAGE_AMOUNT, 32'h0000_FFFF),
            wr(REG_MAX_AMOUNT,     32'h0000_3000),
            chk(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h3000),
            wr(REG_FAR_DISTANCE,   32'h0000_1000),
            chk(24'hFFFFFF, 16'h0000, 16'hFFFF, 16'h0000)
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                drain();
                apb_write(directed_rows[i].idx, directed_rows[i].wdata);
            end
            else
                send_pixel(directed_rows[i].dist_cm, directed_rows[i].mask,
                           directed_rows[i].lum, directed_rows[i].typed,
                           directed_rows[i].want, 8);
        end

        for (int phase = 0; phase < PHASE_N; phase++)
        begin
            configure_phase(phase);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_pixel((phase % 3 == 2) ? 0 : 8);
        end

        start <= 1'b0;
        while (pending_gain.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (err_count == 0)
            $display("sharpen_gain_per_pixel: match");
        else
            $display("sharpen_gain_per_pixel: mismatch");
        $finish;
    end

endmodule
